// ===== rtl/core/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and constants of the earliest-arrival edge scan block.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned TIME_W  = 31;
  localparam int unsigned VERT_W  = 12;
  localparam int unsigned EPOCH_W = 8;

  localparam logic [TIME_W-1:0]  UNREACHED = {TIME_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  // operation codes; the unused code behaves as a read
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_RELAX = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // one label memory word: query tag plus arrival time
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [TIME_W-1:0]  label;
  } label_entry_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_START_FIN
  } seq_state_t;

  typedef struct packed {
    logic in_ready;
    logic finish;
    logic clearing;
  } seq_ctl_t;

endpackage

// ===== rtl/core/tea_label_mem.sv =====
// ----------------------------------------------------------------------------
// tea_label_mem
// Label memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tea_label_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  tea_pkg::label_entry_t wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr_a,
  input  logic [ADDR_W-1:0]     raddr_b,
  output tea_pkg::label_entry_t rdata_a,
  output tea_pkg::label_entry_t rdata_b
);
  import tea_pkg::*;

  label_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/core/tea_seq.sv =====
// ----------------------------------------------------------------------------
// tea_seq
// Item sequencer: accept / execute steps, query epoch and the clearing sweep.
// ----------------------------------------------------------------------------
module tea_seq #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  logic                         is_start,
  input  logic                         out_free,
  output tea_pkg::seq_ctl_t            ctl,
  output logic [ADDR_W-1:0]            clr_addr_r,
  output logic [tea_pkg::EPOCH_W-1:0]  epoch_r,
  output logic [tea_pkg::EPOCH_W-1:0]  wr_epoch
);
  import tea_pkg::*;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

  seq_state_t         state_r, state_nxt;
  logic               pend_start_r, pend_start_nxt;
  logic [ADDR_W-1:0]  clr_addr_nxt;
  logic [EPOCH_W-1:0] epoch_nxt;
  logic               wrap;
  logic               clr_end;

  assign wrap    = (epoch_r == EPOCH_MAX);
  assign clr_end = (state_r == S_CLEAR) && (clr_addr_r == CLR_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_end) begin
          state_nxt = pend_start_r ? S_START_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_start && wrap) begin
          state_nxt = S_CLEAR;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_START_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    ctl.in_ready = 1'b0;
    ctl.finish   = 1'b0;
    ctl.clearing = 1'b0;
    wr_epoch     = epoch_r;
    case (state_r)
      S_CLEAR: ctl.clearing = 1'b1;
      S_IDLE:  ctl.in_ready = 1'b1;
      S_EXEC: begin
        ctl.finish = out_free && !(is_start && wrap);
        // only a start query moves to a new tag
        wr_epoch   = is_start ? epoch_r + 1'b1 : epoch_r;
      end
      S_START_FIN: ctl.finish = out_free;
      default: ctl.clearing = 1'b0;
    endcase
  end

  always_comb begin
    pend_start_nxt = pend_start_r;
    clr_addr_nxt   = clr_addr_r;
    epoch_nxt      = epoch_r;
    if (state_r == S_CLEAR) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_end) begin
        clr_addr_nxt = '0;
        epoch_nxt    = EPOCH_FIRST;
      end
    end
    if ((state_r == S_EXEC) && is_start && wrap) begin
      pend_start_nxt = 1'b1;
    end
    if ((state_r == S_START_FIN) && out_free) begin
      pend_start_nxt = 1'b0;
    end
    if ((state_r == S_EXEC) && ctl.finish && is_start) begin
      epoch_nxt = wr_epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pend_start_r <= 1'b0;
      clr_addr_r   <= '0;
      epoch_r      <= EPOCH_FIRST;
    end else begin
      state_r      <= state_nxt;
      pend_start_r <= pend_start_nxt;
      clr_addr_r   <= clr_addr_nxt;
      epoch_r      <= epoch_nxt;
    end
  end

endmodule

// ===== rtl/core/temporal_earliest_arrival_scan_top.sv =====
// ----------------------------------------------------------------------------
// temporal_earliest_arrival_scan_top
// Earliest-arrival label scan over a stream of time-ordered temporal edges.
// ----------------------------------------------------------------------------
//   channel   ports                                       handshake
//   input     in_operation, in_*_vertex, in_edge_*        in_valid / in_ready
//   result    out_label_value, out_edge_usable, ...       out_valid / out_ready
//   config    cfg_data (start_time)                       cfg_we, no wait
//
// The tail and head labels are read from the label memory in the accept
// cycle and the update is written back in the execute step. Labels carry a
// query tag; a start query bumps the tag, so old labels read as unreached.
// After reset, and on every 255th start query, a clearing sweep resets all
// tags while in_ready stays low.
// A full output register stalls the execute step; the word is held meanwhile.
// ----------------------------------------------------------------------------
module temporal_earliest_arrival_scan_top #(
  parameter int unsigned VERTEX_COUNT = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tea_pkg::TIME_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [tea_pkg::VERT_W-1:0]    in_tail_vertex,
  input  logic [tea_pkg::VERT_W-1:0]    in_head_vertex,
  input  logic [tea_pkg::TIME_W-1:0]    in_edge_departure,
  input  logic [tea_pkg::TIME_W-1:0]    in_edge_arrival,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tea_pkg::TIME_W-1:0]    out_label_value,
  output logic                          out_edge_usable,
  output logic                          out_label_lowered
);
  import tea_pkg::*;

  localparam int unsigned ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

  seq_ctl_t           ctl;
  logic [ADDR_W-1:0]  clr_addr;
  logic [EPOCH_W-1:0] epoch, wr_epoch;
  logic               in_accept, out_free, is_start;

  logic [TIME_W-1:0]  start_time_r;
  logic [1:0]         op_r;
  logic [VERT_W-1:0]  tail_r, head_r;
  logic [TIME_W-1:0]  dep_r, arr_r;

  label_entry_t       rd_tail, rd_head, mem_wdata;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;

  logic               tail_ok, head_ok;
  logic [TIME_W-1:0]  tail_lbl, head_lbl;
  logic [TIME_W-1:0]  res_value;
  logic               res_usable, res_lowered, res_wr, res_wr_head;
  logic [TIME_W-1:0]  res_wlabel;

  logic               out_valid_r;
  logic [TIME_W-1:0]  out_value_r;
  logic               out_usable_r, out_lowered_r;

  assign in_ready  = ctl.in_ready;
  assign in_accept = in_valid && ctl.in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign is_start  = (op_r == OP_START);

  tea_seq #(
    .DEPTH  (VERTEX_COUNT),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .is_start   (is_start),
    .out_free   (out_free),
    .ctl        (ctl),
    .clr_addr_r (clr_addr),
    .epoch_r    (epoch),
    .wr_epoch   (wr_epoch)
  );

  tea_label_mem #(
    .DEPTH  (VERTEX_COUNT),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (in_accept),
    .raddr_a (ADDR_W'(in_tail_vertex)),
    .raddr_b (ADDR_W'(in_head_vertex)),
    .rdata_a (rd_tail),
    .rdata_b (rd_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_time_r <= '0;
    end else if (cfg_we) begin
      start_time_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_operation;
      tail_r <= in_tail_vertex;
      head_r <= in_head_vertex;
      dep_r  <= in_edge_departure;
      arr_r  <= in_edge_arrival;
    end
  end

  // a label counts only if its vertex is in range and its tag belongs to the running query
  assign tail_ok  = (32'(tail_r) < VERTEX_COUNT);
  assign head_ok  = (32'(head_r) < VERTEX_COUNT);
  assign tail_lbl = (tail_ok && (rd_tail.tag == epoch)) ? rd_tail.label : UNREACHED;
  assign head_lbl = (head_ok && (rd_head.tag == epoch)) ? rd_head.label : UNREACHED;

  always_comb begin
    res_value   = tail_lbl;
    res_usable  = 1'b0;
    res_lowered = 1'b0;
    res_wr      = 1'b0;
    res_wr_head = 1'b0;
    res_wlabel  = start_time_r;
    case (op_r)
      OP_START: begin
        res_wr    = tail_ok;
        res_value = tail_ok ? start_time_r : UNREACHED;
      end
      OP_RELAX: begin
        res_usable  = (dep_r >= tail_lbl);
        res_lowered = res_usable && (arr_r < head_lbl) && head_ok;
        res_wr      = res_lowered;
        res_wr_head = 1'b1;
        res_wlabel  = arr_r;
        res_value   = res_lowered ? arr_r : head_lbl;
      end
      OP_READ: res_value = tail_lbl;
      default: res_value = tail_lbl;
    endcase
  end

  always_comb begin
    mem_we          = ctl.clearing || (ctl.finish && res_wr);
    mem_waddr       = res_wr_head ? ADDR_W'(head_r) : ADDR_W'(tail_r);
    mem_wdata.tag   = wr_epoch;
    mem_wdata.label = res_wlabel;
    if (ctl.clearing) begin
      mem_waddr       = clr_addr;
      mem_wdata.tag   = '0;
      mem_wdata.label = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_value_r   <= res_value;
      out_usable_r  <= res_usable;
      out_lowered_r <= res_lowered;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_label_value   = out_value_r;
  assign out_edge_usable   = out_usable_r;
  assign out_label_lowered = out_lowered_r;

endmodule

// ===== rtl/core/tea_checker.sv =====
// ----------------------------------------------------------------------------
// tea_checker
// Port-level checks of the earliest-arrival scan block, bound to the top.
// ----------------------------------------------------------------------------
module tea_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tea_pkg::TIME_W-1:0] out_label_value,
  input logic                       out_edge_usable,
  input logic                       out_label_lowered
);
  import tea_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_label_value)
      && $stable(out_edge_usable) && $stable(out_label_lowered))
    else $error("result word changed while stalled");

  // words are never taken back to back
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  a_lower_usable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_label_lowered |-> out_edge_usable)
    else $error("label lowered by an unusable edge");

  // a lowered label is a real arrival time
  a_lower_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_label_lowered |-> out_label_value != UNREACHED)
    else $error("lowered label reads as unreached");

endmodule

bind temporal_earliest_arrival_scan_top tea_checker u_tea_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_label_value   (out_label_value),
  .out_edge_usable   (out_edge_usable),
  .out_label_lowered (out_label_lowered)
);
